// ===== hw/rtl/mvt_pkg.sv =====
// Shared types, constants and helpers for the 4x4 vertex transform.
// No dependencies; mvt_mac, mvt_div and the top level import this package.
package mvt_pkg;

  localparam int NumRegs  = 8;
  localparam int RegW     = 64;
  localparam int CoordW   = 32;
  localparam int ProdW    = 64;
  localparam int SumW     = 66;
  localparam int FracBits = 16;
  localparam int RowW     = SumW - FracBits;
  localparam int MagW     = RowW - 1;
  localparam int QuotW    = 32;
  localparam int Lanes    = 3;
  localparam int Rows     = 4;
  localparam int DivSteps = QuotW;
  localparam int IdxW     = $clog2(NumRegs);

  typedef logic signed [CoordW-1:0] q16_t;
  typedef logic signed [RowW-1:0]   row_t;
  typedef logic [MagW-1:0]          mag_t;
  typedef logic [QuotW-1:0]         quot_t;
  typedef logic [NumRegs-1:0][RegW-1:0] mtx_t;
  typedef logic [IdxW-1:0]          reg_idx_t;

  typedef enum logic {
    OP_POSITION = 1'b0,
    OP_VECTOR   = 1'b1
  } op_e;

  // Identity matrix: 1.0 on the diagonal in Q16.16. The first entry listed is register 7.
  localparam mtx_t MtxReset = {
    64'h0001_0000_0000_0000, 64'h0,
    64'h0000_0000_0001_0000, 64'h0,
    64'h0, 64'h0001_0000_0000_0000,
    64'h0, 64'h0000_0000_0001_0000
  };

  localparam quot_t QMax = 32'h7FFF_FFFF;
  localparam quot_t QMin = 32'h8000_0000;

  typedef struct packed {
    logic                   op;
    logic                   dz;
    logic [Lanes-1:0]       neg;
    logic [Lanes-1:0]       ovf;
    logic                   vec_sat;
    logic [Lanes-1:0][CoordW-1:0] vec_val;
  } div_ctl_t;

  function automatic q16_t mtx_entry(input mtx_t m, input int r, input int c);
    logic [RegW-1:0] w;
    begin
      w = m[IdxW'((r << 1) | (c >> 1))];
      mtx_entry = ((c & 1) != 0) ? w[RegW-1:CoordW] : w[CoordW-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/mvt_if.sv =====
// Valid/ready channel interfaces for vertex items and transformed results.
// Standalone; no package dependency.
interface mvt_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  modport source (output valid, op, in_x, in_y, in_z, input ready);
  modport sink   (input valid, op, in_x, in_y, in_z, output ready);
endinterface

interface mvt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               divide_by_zero;
  logic               saturated;
  modport source (output valid, out_x, out_y, out_z, divide_by_zero, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, divide_by_zero, saturated,
                  output ready);
endinterface

// ===== hw/rtl/mvt_mac.sv =====
// Two-stage matrix multiply: twelve products, then rounded row sums.
// Depends on mvt_pkg.
module mvt_mac import mvt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  logic  in_op,
  input  q16_t  in_x,
  input  q16_t  in_y,
  input  q16_t  in_z,
  input  mtx_t  mtx,
  output logic  out_valid,
  output logic  out_op,
  output row_t  out_row [Rows]
);

  q16_t                     crd [Lanes];
  logic signed [ProdW-1:0]  prod [Rows][Lanes];
  q16_t                     trans [Rows];
  logic                     v1;
  logic                     op1;
  logic signed [SumW-1:0]   sum [Rows];

  assign crd[0] = in_x;
  assign crd[1] = in_y;
  assign crd[2] = in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= in_op;
      for (int r = 0; r < Rows; r++) begin
        trans[r] <= mtx_entry(mtx, r, Lanes);
        for (int c = 0; c < Lanes; c++) begin
          prod[r][c] <= mtx_entry(mtx, r, c) * crd[c];
        end
      end
    end
  end

  // Exact sum in Q34.32, then round half up by adding one half before the floor.
  always_comb begin
    for (int r = 0; r < Rows; r++) begin
      sum[r] = SumW'(prod[r][0]) + SumW'(prod[r][1]) + SumW'(prod[r][2])
             + SumW'(33'sd32768);
      if (r == Rows - 1 || op1 == OP_POSITION) begin
        sum[r] = sum[r] + (SumW'(trans[r]) <<< FracBits);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_op <= op1;
      for (int r = 0; r < Rows; r++) begin
        out_row[r] <= sum[r][SumW-1:FracBits];
      end
    end
  end

endmodule

// ===== hw/rtl/mvt_div.sv =====
// Perspective divide: sign/overflow preparation, then a restoring divider
// that resolves one quotient bit per stage for x, y and z. Depends on mvt_pkg.
module mvt_div import mvt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  logic     in_valid,
  input  logic     in_op,
  input  row_t     in_row [Rows],
  output logic     out_valid,
  output div_ctl_t out_ctl,
  output quot_t    out_quot [Lanes]
);

  div_ctl_t ctl_prep;
  mag_t     an_prep [Lanes];
  mag_t     ad_prep;
  row_t     dw;

  logic     vs [DivSteps+1];
  div_ctl_t cs [DivSteps+1];
  mag_t     rs [DivSteps+1][Lanes];
  mag_t     as [DivSteps+1][Lanes];
  mag_t     ds [DivSteps+1];
  quot_t    qs [DivSteps+1][Lanes];

  always_comb begin
    dw = in_row[Rows-1];
    ad_prep = dw[RowW-1] ? MagW'(-dw) : MagW'(dw);
    ctl_prep = '0;
    ctl_prep.op = in_op;
    ctl_prep.dz = (in_op == OP_POSITION) && (dw == '0);
    for (int k = 0; k < Lanes; k++) begin
      an_prep[k] = in_row[k][RowW-1] ? MagW'(-in_row[k]) : MagW'(in_row[k]);
      ctl_prep.neg[k] = in_row[k][RowW-1] ^ dw[RowW-1];
      // The quotient reaches 2^32 exactly when |n| >= |w| * 2^16.
      ctl_prep.ovf[k] = (an_prep[k] >> FracBits) >= ad_prep;
      if ((&in_row[k][RowW-1:CoordW-1]) || !(|in_row[k][RowW-1:CoordW-1])) begin
        ctl_prep.vec_val[k] = in_row[k][CoordW-1:0];
      end else begin
        ctl_prep.vec_sat = 1'b1;
        ctl_prep.vec_val[k] = in_row[k][RowW-1] ? QMin : QMax;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs[0] <= 1'b0;
    end else if (adv) begin
      vs[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs[0] <= ctl_prep;
      ds[0] <= ad_prep;
      for (int k = 0; k < Lanes; k++) begin
        as[0][k] <= an_prep[k];
        rs[0][k] <= an_prep[k] >> FracBits;
        qs[0][k] <= '0;
      end
    end
  end

  for (genvar s = 0; s < DivSteps; s++) begin : g_step
    localparam int Bit = DivSteps - 1 - s;
    logic [MagW:0] trial [Lanes];
    logic          ge [Lanes];
    logic          nbit [Lanes];

    always_comb begin
      for (int k = 0; k < Lanes; k++) begin
        if (Bit >= FracBits) begin
          nbit[k] = as[s][k][Bit - FracBits];
        end else begin
          nbit[k] = 1'b0;
        end
        trial[k] = {rs[s][k], nbit[k]};
        ge[k] = trial[k] >= {1'b0, ds[s]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[s+1] <= 1'b0;
      end else if (adv) begin
        vs[s+1] <= vs[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs[s+1] <= cs[s];
        ds[s+1] <= ds[s];
        for (int k = 0; k < Lanes; k++) begin
          as[s+1][k] <= as[s][k];
          rs[s+1][k] <= ge[k] ? MagW'(trial[k] - {1'b0, ds[s]}) : MagW'(trial[k]);
          qs[s+1][k] <= qs[s][k] | (QuotW'(ge[k]) << Bit);
        end
      end
    end
  end

  assign out_valid = vs[DivSteps];
  assign out_ctl   = cs[DivSteps];
  for (genvar k = 0; k < Lanes; k++) begin : g_out
    assign out_quot[k] = qs[DivSteps][k];
  end

endmodule

// ===== hw/rtl/matrix4_vertex_transform.sv =====
// Top level of the 4x4 vertex transform: matrix registers, pipeline, output stage.
// Depends on mvt_pkg, mvt_if, mvt_mac and mvt_div.
//
// Takes one vertex per clock while the output is not stalled and returns one
// result per vertex, in order, through two stages of multiply and row sum, one
// stage of sign and overflow preparation, 32 stages of the restoring divider
// (one quotient bit each), and the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so a stalled output
// holds every stage. Matrix writes go straight into the registers and must only
// happen while no vertex is in flight; reset loads the identity matrix.
module matrix4_vertex_transform import mvt_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  reg_idx_t        cfg_index,
  input  logic [RegW-1:0] cfg_data,
  mvt_in_if.sink          vtx_in,
  mvt_out_if.source       vtx_out
);

  mtx_t     mtx;
  logic     adv;
  logic     mac_valid;
  logic     mac_op;
  row_t     mac_row [Rows];
  logic     div_valid;
  div_ctl_t div_ctl;
  quot_t    div_quot [Lanes];
  quot_t    res_next [Lanes];
  logic     lane_sat [Lanes];
  logic     sat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mtx <= MtxReset;
    end else if (cfg_we) begin
      mtx[cfg_index] <= cfg_data;
    end
  end

  assign adv = !vtx_out.valid || vtx_out.ready;
  assign vtx_in.ready = adv;

  mvt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vtx_in.valid),
    .in_op     (vtx_in.op),
    .in_x      (vtx_in.in_x),
    .in_y      (vtx_in.in_y),
    .in_z      (vtx_in.in_z),
    .mtx       (mtx),
    .out_valid (mac_valid),
    .out_op    (mac_op),
    .out_row   (mac_row)
  );

  mvt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (mac_valid),
    .in_op     (mac_op),
    .in_row    (mac_row),
    .out_valid (div_valid),
    .out_ctl   (div_ctl),
    .out_quot  (div_quot)
  );

  // Vectors pass; zero if w = 0, else sign and clamp (negatives may reach 2^31).
  always_comb begin
    sat_next = 1'b0;
    for (int k = 0; k < Lanes; k++) begin
      lane_sat[k] = 1'b0;
      res_next[k] = div_quot[k];
      if (div_ctl.op == OP_VECTOR) begin
        res_next[k] = div_ctl.vec_val[k];
      end else if (div_ctl.dz) begin
        res_next[k] = '0;
      end else if (div_ctl.ovf[k]) begin
        lane_sat[k] = 1'b1;
        res_next[k] = div_ctl.neg[k] ? QMin : QMax;
      end else if (div_ctl.neg[k]) begin
        if (div_quot[k] > QMin) begin
          lane_sat[k] = 1'b1;
          res_next[k] = QMin;
        end else begin
          res_next[k] = -div_quot[k];
        end
      end else if (div_quot[k] > QMax) begin
        lane_sat[k] = 1'b1;
        res_next[k] = QMax;
      end
      sat_next = sat_next | lane_sat[k];
    end
    if (div_ctl.op == OP_VECTOR) begin
      sat_next = div_ctl.vec_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vtx_out.valid <= 1'b0;
    end else if (adv) begin
      vtx_out.valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx_out.out_x          <= res_next[0];
      vtx_out.out_y          <= res_next[1];
      vtx_out.out_z          <= res_next[2];
      vtx_out.divide_by_zero <= div_ctl.dz;
      vtx_out.saturated      <= sat_next;
    end
  end

  a_dz_no_sat: assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid && vtx_out.divide_by_zero |-> !vtx_out.saturated)
    else $error("divide_by_zero and saturated raised together");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid && vtx_out.divide_by_zero |->
      vtx_out.out_x == 0 && vtx_out.out_y == 0 && vtx_out.out_z == 0)
    else $error("nonzero result on zero w");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    vtx_out.valid && !vtx_out.ready |-> !vtx_in.ready)
    else $error("input accepted while the pipeline is stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !vtx_out.valid)
    else $error("result valid right after reset");

endmodule
